[rtl/akw_pkg.sv]
package akw_pkg;

   localparam int MaxSemiblocks = 32;
   localparam int IdxW = $clog2(MaxSemiblocks);
   localparam int CntW = 7;
   localparam logic [63:0] IntegrityIv = 64'hA6A6A6A6A6A6A6A6;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusFail = 2'd1;
   localparam logic [1:0] StatusLenErr = 2'd2;

   localparam logic CsrKeyHigh = 1'b0;
   localparam logic CsrKeyLow = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_KEYEXP,
      ST_RDSTEP,
      ST_DECRYPT,
      ST_RDOUT,
      ST_EMIT,
      ST_ERR
   } state_type;

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] x2;
      logic [7:0] x4;
      logic [7:0] x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      gmul = (m[0] ? a : 8'h00) ^ (m[1] ? x2 : 8'h00) ^ (m[2] ? x4 : 8'h00)
           ^ (m[3] ? x8 : 8'h00);
   endfunction

   function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            p = p ^ x;
         end
         x = xtime(x);
      end
      gmul8 = p;
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] base;
      logic [7:0] e;
      r = 8'h01;
      base = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) begin
            r = gmul8(r, base);
         end
         base = gmul8(base, base);
      end
      if (x == 8'h00) begin
         r = 8'h00;
      end
      sbox = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
           ^ {r[3:0], r[7:4]} ^ 8'h63;
   endfunction

   // inverse box found by searching the forward box for each input
   function automatic logic [7:0] inv_sbox(input logic [7:0] y);
      logic [7:0] res;
      res = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (sbox(8'(i)) == y) begin
            res = 8'(i);
         end
      end
      inv_sbox = res;
   endfunction

endpackage

[rtl/akw_tables.sv]
module akw_tables (
   input  logic [31:0] fwd_in,
   output logic [31:0] fwd_out,
   input  logic [127:0] inv_in,
   output logic [127:0] inv_out
);

   logic [7:0] fwd_rom [256];
   logic [7:0] inv_rom [256];

   always_comb begin
      for (int i = 0; i < 256; i++) begin
         fwd_rom[i] = akw_pkg::sbox(8'(i));
         inv_rom[i] = akw_pkg::inv_sbox(8'(i));
      end
   end

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         fwd_out[8*b +: 8] = fwd_rom[fwd_in[8*b +: 8]];
      end
      for (int b = 0; b < 16; b++) begin
         inv_out[8*b +: 8] = inv_rom[inv_in[8*b +: 8]];
      end
   end

endmodule

[rtl/akw_round.sv]
module akw_round (
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         last_round,
   output logic [127:0] sub_idx,
   input  logic [127:0] sub_val,
   output logic [127:0] state_out
);

   // byte k sits at bits 127-8k
   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] u [16];
   logic [7:0] m [16];

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         s[k] = state_in[127-8*k -: 8];
      end
      // inverse shift rows feeds the box lookups
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            sub_idx[127-8*(r+4*c) -: 8] = s[r + 4*((c - r + 4) % 4)];
         end
      end
      for (int k = 0; k < 16; k++) begin
         t[k] = sub_val[127-8*k -: 8] ^ round_key[127-8*k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         m[4*c]   = akw_pkg::gmul(t[4*c], 4'd14) ^ akw_pkg::gmul(t[4*c+1], 4'd11)
                  ^ akw_pkg::gmul(t[4*c+2], 4'd13) ^ akw_pkg::gmul(t[4*c+3], 4'd9);
         m[4*c+1] = akw_pkg::gmul(t[4*c], 4'd9) ^ akw_pkg::gmul(t[4*c+1], 4'd14)
                  ^ akw_pkg::gmul(t[4*c+2], 4'd11) ^ akw_pkg::gmul(t[4*c+3], 4'd13);
         m[4*c+2] = akw_pkg::gmul(t[4*c], 4'd13) ^ akw_pkg::gmul(t[4*c+1], 4'd9)
                  ^ akw_pkg::gmul(t[4*c+2], 4'd14) ^ akw_pkg::gmul(t[4*c+3], 4'd11);
         m[4*c+3] = akw_pkg::gmul(t[4*c], 4'd11) ^ akw_pkg::gmul(t[4*c+1], 4'd13)
                  ^ akw_pkg::gmul(t[4*c+2], 4'd9) ^ akw_pkg::gmul(t[4*c+3], 4'd14);
      end
      for (int k = 0; k < 16; k++) begin
         u[k] = last_round ? t[k] : m[k];
         state_out[127-8*k -: 8] = u[k];
      end
   end

endmodule

[rtl/aes128_key_unwrap_unit.sv]
// after the final request: key expansion, then 6*n steps (a store read, the key-10
// addition and rounds 9 to 0), then n results, each a store read and an emit that
// waits for the receiver; a length error gives its single result in the cycle after
// the final request
// one request is taken per cycle while loading; none while an unwrap runs or drains
// reset is synchronous and clears control state; store contents are undefined
module aes128_key_unwrap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // semiblock
   input  logic        req_tlast,   // final_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // plain_block
   output logic        rsp_tlast,   // last_result
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [63:0] csr_wdata
);

   localparam int IW = akw_pkg::IdxW;
   localparam int CW = akw_pkg::CntW;

   akw_pkg::state_type state_ff, state_in;

   logic [63:0] key_high_ff, key_low_ff;
   logic [63:0] a_ff, a_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic ovf_ff, ovf_in;
   logic [IW-1:0] n_ff, n_in;        // n-1
   logic [IW-1:0] k_ff, k_in;        // k-1
   logic [2:0] j_ff, j_in;
   logic [3:0] rnd_ff, rnd_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] rk_cur_ff, rk_cur_in;
   logic [3:0] rcon_idx_ff, rcon_idx_in;
   logic [7:0] rcon_ff, rcon_in;

   logic [63:0] sb_mem [akw_pkg::MaxSemiblocks];
   logic [127:0] rk_mem [11];
   logic sb_we;
   logic [IW-1:0] sb_waddr, sb_raddr;
   logic [63:0] sb_wdata, sb_rdata_ff;
   logic rk_we;
   logic [3:0] rk_waddr, rk_raddr;
   logic [127:0] rk_rdata_ff;

   always_ff @(posedge clock) begin
      if (sb_we) begin
         sb_mem[sb_waddr] <= sb_wdata;
      end
      sb_rdata_ff <= sb_mem[sb_raddr];
      if (rk_we) begin
         rk_mem[rk_waddr] <= rk_cur_in;
      end
      rk_rdata_ff <= rk_mem[rk_raddr];
   end

   // key schedule step and box tables
   logic [31:0] ks_sub;
   logic [127:0] inv_idx, inv_val, rnd_out, rk_next;
   akw_tables u_tab (
      .fwd_in ({rk_cur_ff[23:0], rk_cur_ff[31:24]}),
      .fwd_out(ks_sub),
      .inv_in (inv_idx),
      .inv_out(inv_val)
   );
   akw_round u_rnd (
      .state_in  (st_ff),
      .round_key (rk_rdata_ff),
      .last_round(rnd_ff == 4'd0),
      .sub_idx   (inv_idx),
      .sub_val   (inv_val),
      .state_out (rnd_out)
   );

   always_comb begin
      rk_next[127:96] = rk_cur_ff[127:96] ^ ks_sub ^ {rcon_ff, 24'h0};
      rk_next[95:64] = rk_cur_ff[95:64] ^ rk_next[127:96];
      rk_next[63:32] = rk_cur_ff[63:32] ^ rk_next[95:64];
      rk_next[31:0] = rk_cur_ff[31:0] ^ rk_next[63:32];
   end

   logic req_hs, rsp_hs;
   logic [63:0] ctr;
   assign req_hs = req_tvalid && req_tready;
   assign rsp_hs = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == akw_pkg::ST_LOAD);
   // counter n*j + k, narrow values
   assign ctr = 64'((IW+1+3)'({1'b0, n_ff} + 1'b1) * (IW+1+3)'(j_ff))
              + 64'({1'b0, k_ff}) + 64'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         akw_pkg::ST_LOAD: begin
            if (req_hs && req_tlast) begin
               if (cnt_ff == '0 || ovf_ff ||
                   (cnt_ff > CW'(akw_pkg::MaxSemiblocks))) begin
                  state_in = akw_pkg::ST_ERR;
               end else begin
                  state_in = akw_pkg::ST_KEYEXP;
               end
            end
         end
         akw_pkg::ST_KEYEXP: if (rcon_idx_ff == 4'd9) state_in = akw_pkg::ST_RDSTEP;
         akw_pkg::ST_RDSTEP: state_in = akw_pkg::ST_DECRYPT;
         akw_pkg::ST_DECRYPT: begin
            if (rnd_ff == 4'd0) begin
               if (k_ff == '0 && j_ff == 3'd0) state_in = akw_pkg::ST_RDOUT;
               else state_in = akw_pkg::ST_RDSTEP;
            end
         end
         akw_pkg::ST_RDOUT: state_in = akw_pkg::ST_EMIT;
         akw_pkg::ST_EMIT: begin
            if (rsp_hs) begin
               state_in = (k_ff == n_ff) ? akw_pkg::ST_LOAD : akw_pkg::ST_RDOUT;
            end
         end
         akw_pkg::ST_ERR: if (rsp_hs) state_in = akw_pkg::ST_LOAD;
         default: state_in = akw_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      a_in = a_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      n_in = n_ff;
      k_in = k_ff;
      j_in = j_ff;
      rnd_in = rnd_ff;
      st_in = st_ff;
      rk_cur_in = rk_cur_ff;
      rcon_idx_in = rcon_idx_ff;
      rcon_in = rcon_ff;
      sb_we = 1'b0;
      sb_waddr = k_ff;
      sb_wdata = rnd_out[63:0];
      sb_raddr = k_ff;
      rk_we = 1'b0;
      rk_waddr = rcon_idx_ff;
      rk_raddr = rnd_ff;
      case (state_ff)
         akw_pkg::ST_LOAD: begin
            if (req_hs) begin
               if (cnt_ff == '0) a_in = req_tdata;
               else if (cnt_ff <= CW'(akw_pkg::MaxSemiblocks)) begin
                  sb_we = 1'b1;
                  sb_waddr = IW'(cnt_ff - 1'b1);
                  sb_wdata = req_tdata;
               end else ovf_in = 1'b1;
               if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
               if (req_tlast) begin
                  n_in = IW'(cnt_ff - 1'b1);
                  k_in = IW'(cnt_ff - 1'b1);
                  j_in = 3'd5;
                  rk_cur_in = {key_high_ff, key_low_ff};
                  rk_we = 1'b1;
                  rk_waddr = 4'd0;
                  rcon_idx_in = 4'd0;
                  rcon_in = 8'h01;
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         akw_pkg::ST_KEYEXP: begin
            rk_cur_in = rk_next;
            rk_we = 1'b1;
            rk_waddr = rcon_idx_ff + 1'b1;
            rcon_idx_in = rcon_idx_ff + 1'b1;
            rcon_in = akw_pkg::xtime(rcon_ff);
            rnd_in = 4'd10;
         end
         akw_pkg::ST_RDSTEP: begin
            // store and round key 10 arrive next cycle; add key there
            rnd_in = 4'd10;
            rk_raddr = 4'd10;
         end
         akw_pkg::ST_DECRYPT: begin
            rk_raddr = (rnd_ff == 4'd0) ? 4'd10 : rnd_ff - 1'b1;
            if (rnd_ff == 4'd10) begin
               st_in = {a_ff ^ ctr, sb_rdata_ff} ^ rk_rdata_ff;
               rnd_in = 4'd9;
            end else begin
               st_in = rnd_out;
               rnd_in = rnd_ff - 1'b1;
               if (rnd_ff == 4'd0) begin
                  a_in = rnd_out[127:64];
                  sb_we = 1'b1;
                  rnd_in = 4'd10;
                  if (k_ff == '0) begin
                     k_in = n_ff;
                     j_in = j_ff - 1'b1;
                     if (j_ff == 3'd0) k_in = '0;
                  end else k_in = k_ff - 1'b1;
               end
            end
         end
         akw_pkg::ST_RDOUT: begin
            sb_raddr = k_ff;
         end
         akw_pkg::ST_EMIT: begin
            if (rsp_hs) begin
               k_in = k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // the rnd_ff==10 decrypt cycle applies key 10; round 9 key is read then
   // other rounds use the key read the previous cycle

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= akw_pkg::ST_LOAD;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         a_ff <= '0;
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         a_ff <= a_in;
         if (csr_we && csr_addr == akw_pkg::CsrKeyHigh) key_high_ff <= csr_wdata;
         if (csr_we && csr_addr == akw_pkg::CsrKeyLow) key_low_ff <= csr_wdata;
      end
      n_ff <= n_in;
      k_ff <= k_in;
      j_ff <= j_in;
      rnd_ff <= rnd_in;
      st_ff <= st_in;
      rk_cur_ff <= rk_cur_in;
      rcon_idx_ff <= rcon_idx_in;
      rcon_ff <= rcon_in;
   end

   // result shown directly from the state, registered payload
   assign rsp_tvalid = (state_ff == akw_pkg::ST_EMIT) || (state_ff == akw_pkg::ST_ERR);
   assign rsp_tdata = (state_ff == akw_pkg::ST_ERR) ? 64'd0 : sb_rdata_ff;
   assign rsp_tlast = (state_ff == akw_pkg::ST_ERR) || (k_ff == n_ff);
   assign rsp_tuser = (state_ff == akw_pkg::ST_ERR) ? akw_pkg::StatusLenErr
                    : ((a_ff == akw_pkg::IntegrityIv) ? akw_pkg::StatusOk
                                                      : akw_pkg::StatusFail);

`ifndef ASSERT_OFF
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != akw_pkg::ST_LOAD) |-> !req_tready)
      else $error("request taken during unwrap");
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == akw_pkg::ST_ERR && rsp_tready) |=> (state_ff == akw_pkg::ST_LOAD))
      else $error("length error gave more than one result");
   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      (req_hs && req_tlast) |=> (cnt_ff == '0 && !ovf_ff))
      else $error("counters not cleared after final request");
`endif

endmodule

[test/testbench.sv]
module testbench;

   typedef struct packed {
      logic [63:0] word;
      logic        fin;
   } req_item_t;

   typedef struct packed {
      logic [63:0] plain;
      logic        last;
      logic [1:0]  status;
   } plain_result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_we;
   logic        csr_addr;
   logic [63:0] csr_wdata;

   aes128_key_unwrap_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   req_item_t     pending_reqs[$];
   plain_result_t expected_plain[$];
   int            send_idle_pct;
   int            recv_stall_pct;
   int            mismatches;
   int            accepted_reqs;
   bit            hold_sender;

   // predictor state
   logic [63:0]  kek_high, kek_low;
   logic [63:0]  wrapped_store[akw_pkg::MaxSemiblocks];
   logic [63:0]  integrity_reg;
   int           loaded_count;
   bit           too_long;
   logic [7:0]   fwd_sb[256];
   logic [7:0]   inv_sb[256];
   logic [7:0]   rkeys[11][16];

   function automatic logic [7:0] ff_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      logic [8:0] x;
      p = 8'h00;
      x = {1'b0, a};
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= x[7:0];
         x = x << 1;
         if (x[8]) x ^= 9'h11B;
      end
      return p;
   endfunction

   task automatic build_sboxes();
      logic [7:0] r, base, s;
      for (int x = 0; x < 256; x++) begin
         r = 8'd1;
         base = 8'(x);
         for (int i = 0; i < 8; i++) begin
            if ((254 >> i) & 1) r = ff_mul(r, base);
            base = ff_mul(base, base);
         end
         if (x == 0) r = 8'd0;
         s = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
             ^ {r[3:0], r[7:4]} ^ 8'h63;
         fwd_sb[x] = s;
         inv_sb[s] = 8'(x);
      end
   endtask

   task automatic expand_kek();
      logic [7:0] rc;
      rc = 8'd1;
      for (int i = 0; i < 8; i++) begin
         rkeys[0][i] = kek_high[63 - 8*i -: 8];
         rkeys[0][8+i] = kek_low[63 - 8*i -: 8];
      end
      for (int r = 1; r <= 10; r++) begin
         rkeys[r][0] = rkeys[r-1][0] ^ fwd_sb[rkeys[r-1][13]] ^ rc;
         rkeys[r][1] = rkeys[r-1][1] ^ fwd_sb[rkeys[r-1][14]];
         rkeys[r][2] = rkeys[r-1][2] ^ fwd_sb[rkeys[r-1][15]];
         rkeys[r][3] = rkeys[r-1][3] ^ fwd_sb[rkeys[r-1][12]];
         for (int i = 4; i < 16; i++) rkeys[r][i] = rkeys[r-1][i] ^ rkeys[r][i-4];
         rc = ff_mul(rc, 8'h02);
      end
   endtask

   function automatic logic [127:0] aes_decrypt(logic [127:0] blk);
      logic [7:0] s[16];
      logic [7:0] t[16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8] ^ rkeys[10][i];
      for (int r = 9; r >= 0; r--) begin
         for (int row = 0; row < 4; row++)
            for (int c = 0; c < 4; c++)
               t[row + 4*c] = inv_sb[s[row + 4*((c - row + 4) & 3)]];
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkeys[r][i];
         if (r > 0) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
               s[4*c]   = ff_mul(a0, 8'd14) ^ ff_mul(a1, 8'd11) ^ ff_mul(a2, 8'd13)
                        ^ ff_mul(a3, 8'd9);
               s[4*c+1] = ff_mul(a0, 8'd9) ^ ff_mul(a1, 8'd14) ^ ff_mul(a2, 8'd11)
                        ^ ff_mul(a3, 8'd13);
               s[4*c+2] = ff_mul(a0, 8'd13) ^ ff_mul(a1, 8'd9) ^ ff_mul(a2, 8'd14)
                        ^ ff_mul(a3, 8'd11);
               s[4*c+3] = ff_mul(a0, 8'd11) ^ ff_mul(a1, 8'd13) ^ ff_mul(a2, 8'd9)
                        ^ ff_mul(a3, 8'd14);
            end
         end
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
   endfunction

   task automatic predict_unwrap(req_item_t it);
      logic [63:0]  a;
      logic [127:0] d;
      int           n;
      if (loaded_count == 0) integrity_reg = it.word;
      else if (loaded_count - 1 < akw_pkg::MaxSemiblocks)
         wrapped_store[loaded_count-1] = it.word;
      else too_long = 1;
      if (loaded_count < 127) loaded_count++;
      if (!it.fin) return;
      if (loaded_count < 2 || too_long) begin
         expected_plain.push_back('{64'd0, 1'b1, akw_pkg::StatusLenErr});
      end else begin
         n = loaded_count - 1;
         expand_kek();
         a = integrity_reg;
         for (int j = 5; j >= 0; j--) begin
            for (int k = n; k >= 1; k--) begin
               a ^= 64'(n * j + k);
               d = aes_decrypt({a, wrapped_store[k-1]});
               a = d[127:64];
               wrapped_store[k-1] = d[63:0];
            end
         end
         for (int k = 0; k < n; k++)
            expected_plain.push_back('{wrapped_store[k], k == n - 1,
                                       (a == akw_pkg::IntegrityIv) ? akw_pkg::StatusOk
                                                                   : akw_pkg::StatusFail});
      end
      loaded_count = 0;
      too_long = 0;
      integrity_reg = 0;
   endtask

   task automatic queue_unwrap(int n, bit good_iv);
      logic [63:0] w;
      for (int i = 0; i <= n; i++) begin
         w = {$urandom, $urandom};
         if (i == 0 && good_iv) w = akw_pkg::IntegrityIv;
         pending_reqs.push_back('{w, i == n});
      end
   endtask

   task automatic write_csr(logic idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == akw_pkg::CsrKeyHigh) kek_high = val;
      else kek_low = val;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_plain.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("testbench failed");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_unwrap('{req_tdata, req_tlast});
            accepted_reqs++;
            void'(pending_reqs.pop_front());
         end
         if (pending_reqs.size() > 0 && !hold_sender
             && (!(req_tvalid && !req_tready) ? $urandom_range(99) >= send_idle_pct : 1)) begin
            req_tvalid <= 1;
            req_tdata <= pending_reqs[0].word;
            req_tlast <= pending_reqs[0].fin;
         end else if (!(req_tvalid && !req_tready)) begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      plain_result_t want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_plain.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = expected_plain.pop_front();
               if (rsp_tdata !== want.plain || rsp_tlast !== want.last
                   || rsp_tuser !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
                              want.plain, want.last, want.status,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   initial begin
      int n;
      reset = 1;
      req_tvalid = 0; req_tdata = 0; req_tlast = 0;
      rsp_tready = 0;
      csr_we = 0; csr_addr = akw_pkg::CsrKeyHigh; csr_wdata = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      mismatches = 0; accepted_reqs = 0; hold_sender = 0;
      kek_high = 0; kek_low = 0; integrity_reg = 0; loaded_count = 0; too_long = 0;
      build_sboxes();
      repeat (2) @(posedge clock);
      reset <= 0;

      // zero key, then directed cases
      pending_reqs.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1});  // too short
      queue_unwrap(1, 1);
      queue_unwrap(2, 0);
      drain();
      write_csr(akw_pkg::CsrKeyHigh, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(akw_pkg::CsrKeyLow, 64'hFFFF_FFFF_FFFF_FFFF);
      pending_reqs.push_back('{64'h0, 1'b0});
      pending_reqs.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
      queue_unwrap(akw_pkg::MaxSemiblocks + 1, 1);  // too long
      drain();
      write_csr(akw_pkg::CsrKeyHigh, 64'h0001_0203_0405_0607);
      write_csr(akw_pkg::CsrKeyLow, 64'h0809_0A0B_0C0D_0E0F);
      // known answer from the standard's 128-bit example
      pending_reqs.push_back('{64'h1FA6_8B0A_8112_B447, 1'b0});
      pending_reqs.push_back('{64'hAEF3_4BD8_FB5A_7B82, 1'b0});
      pending_reqs.push_back('{64'h9D3E_8623_71D2_CFE5, 1'b1});
      queue_unwrap(akw_pkg::MaxSemiblocks, 1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? 87 : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? 87 : 0;
         if (phase == 3) begin
            send_idle_pct = 31;
            recv_stall_pct = 31;
         end
         write_csr(akw_pkg::CsrKeyHigh, {$urandom, $urandom});
         write_csr(akw_pkg::CsrKeyLow, {$urandom, $urandom});
         for (int u = 0; u < 5; u++) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(akw_pkg::MaxSemiblocks + 3, 0)
                                          : $urandom_range(6, 1);
            queue_unwrap(n, $urandom_range(3) != 0);
         end
         if (phase == 1) begin
            // sender waits for every outstanding result
            while (pending_reqs.size() > 0) @(posedge clock);
            hold_sender = 1;
            queue_unwrap(2, 1);
            while (expected_plain.size() > 0) @(posedge clock);
            hold_sender = 0;
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
